// ===== sv/drrt_pkg.sv =====
package drrt_pkg;

	localparam int DEF_RING_SIZE  = 256;
	localparam int DEF_READ_LIMIT = 64;

	localparam int CMD_W   = 3;
	localparam int CNT_W   = 16;
	localparam int TOT_W   = 32;
	localparam int AVAIL_W = 9;
	localparam int START_W = 8;
	localparam int GCNT_W  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_OBSERVE = 3'd0,
		CMD_GRANT   = 3'd1,
		CMD_COMMIT  = 3'd2,
		CMD_FLUSH   = 3'd3,
		CMD_STOP    = 3'd4,
		CMD_RESTART = 3'd5
	} cmd_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OBS,
		S_CHK,
		S_ACT,
		S_FIN,
		S_OUT
	} drrt_state_t;

	// One strobe per datapath step, issued by the controller.
	typedef struct packed {
		logic capture;
		logic observe;
		logic check;
		logic act;
		logic finish;
	} drrt_ctl_t;

endpackage

// ===== sv/drrt_ctrl.sv =====
module drrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output drrt_pkg::drrt_ctl_t ctl
);
	import drrt_pkg::*;

	drrt_state_t state_q;
	drrt_state_t state_d;
	logic        accept;

	// The result cycle is also free to take the next item.
	assign busy   = !(state_q == S_IDLE || state_q == S_OUT);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_OBS;
				end
			end
			S_OBS: state_d = S_CHK;
			S_CHK: state_d = S_ACT;
			S_ACT: state_d = S_FIN;
			S_FIN: state_d = S_OUT;
			S_OUT: begin
				state_d = accept ? S_OBS : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl         = '0;
		ctl.capture = accept;
		done        = 1'b0;
		unique case (state_q)
			S_OBS:   ctl.observe = 1'b1;
			S_CHK:   ctl.check   = 1'b1;
			S_ACT:   ctl.act     = 1'b1;
			S_FIN:   ctl.finish  = 1'b1;
			S_OUT:   done        = 1'b1;
			default: ;
		endcase
	end

	a_accept_goes_obs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_OBS)
		else $error("accepted item did not enter observation step");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl.finish))
		else $error("result strobe without finish step");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.observe, ctl.check, ctl.act, ctl.finish, done}))
		else $error("more than one step active");

endmodule

// ===== sv/drrt_dp.sv =====
module drrt_dp #(
	parameter int RING_SIZE  = drrt_pkg::DEF_RING_SIZE,
	parameter int READ_LIMIT = drrt_pkg::DEF_READ_LIMIT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  drrt_pkg::drrt_ctl_t          ctl,
	input  logic [drrt_pkg::CMD_W-1:0]   command,
	input  logic                         dma_error,
	input  logic                         half_mark,
	input  logic                         full_mark,
	input  logic [drrt_pkg::CNT_W-1:0]   remaining,
	input  logic                         line_error,
	input  logic [drrt_pkg::CNT_W-1:0]   read_max,
	output logic [drrt_pkg::AVAIL_W-1:0] available,
	output logic [drrt_pkg::START_W-1:0] grant_start,
	output logic [drrt_pkg::GCNT_W-1:0]  grant_count,
	output logic                         faulted,
	output logic [drrt_pkg::TOT_W-1:0]   error_total,
	output logic [drrt_pkg::TOT_W-1:0]   overflow_total
);
	import drrt_pkg::*;

	localparam int RW = $clog2(RING_SIZE);
	localparam int PW = $clog2(READ_LIMIT + 1);
	localparam logic [CNT_W-1:0] RING_MASK = CNT_W'(RING_SIZE - 1);
	localparam logic [CNT_W:0]   RING_EXT  = (CNT_W + 1)'(RING_SIZE);
	localparam logic [CNT_W-1:0] LIMIT     = CNT_W'(READ_LIMIT);

	// Captured item.
	cmd_code_t        cmd_q;
	logic             dma_err_q;
	logic             half_q;
	logic             full_q;
	logic [CNT_W-1:0] rem_q;
	logic             line_q;
	logic [CNT_W-1:0] req_q;

	// Tracker state.
	logic [CNT_W-1:0] wc_q;
	logic [CNT_W-1:0] rc_q;
	logic [RW-1:0]    last_q;
	logic             fault_q;
	logic             recv_q;
	logic [TOT_W-1:0] err_q;
	logic [TOT_W-1:0] ovf_q;
	logic [PW-1:0]    pend_q;

	// Result.
	logic [AVAIL_W-1:0] avail_q;
	logic [START_W-1:0] gstart_q;
	logic [GCNT_W-1:0]  gcount_q;

	logic             obs_en;
	logic [CNT_W-1:0] pos16;
	logic [RW-1:0]    delta;
	logic [CNT_W-1:0] fill;
	logic [CNT_W-1:0] req_cl;
	logic [CNT_W-1:0] grant_n;
	logic [CNT_W-1:0] commit_n;
	logic [CNT_W-1:0] start16;
	logic             rem_bad;

	assign obs_en   = (cmd_q inside {CMD_OBSERVE, CMD_GRANT, CMD_COMMIT, CMD_FLUSH})
		&& recv_q && !fault_q;
	assign pos16    = (CNT_W'(RING_SIZE) - rem_q) & RING_MASK;
	assign delta    = pos16[RW-1:0] - last_q;
	assign fill     = wc_q - rc_q;
	assign rem_bad  = {1'b0, rem_q} > RING_EXT;
	assign req_cl   = (req_q > LIMIT) ? LIMIT : req_q;
	assign grant_n  = fault_q ? '0 : ((fill < req_cl) ? fill : req_cl);
	assign commit_n = fault_q ? '0 : CNT_W'(pend_q);
	assign start16  = rc_q & RING_MASK;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q     <= cmd_code_t'(command);
			dma_err_q <= dma_error;
			half_q    <= half_mark;
			full_q    <= full_mark;
			rem_q     <= remaining;
			line_q    <= line_error;
			req_q     <= read_max;
		end
		if (ctl.act) begin
			case (cmd_q)
				CMD_GRANT: begin
					gstart_q <= start16[START_W-1:0];
					gcount_q <= grant_n[GCNT_W-1:0];
				end
				CMD_COMMIT: begin
					gstart_q <= start16[START_W-1:0];
					gcount_q <= commit_n[GCNT_W-1:0];
				end
				default: begin
					gstart_q <= '0;
					gcount_q <= '0;
				end
			endcase
		end
		if (ctl.finish) begin
			avail_q <= fault_q ? '0 : fill[AVAIL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q    <= '0;
			rc_q    <= '0;
			last_q  <= '0;
			fault_q <= 1'b0;
			recv_q  <= 1'b0;
			err_q   <= '0;
			ovf_q   <= '0;
			pend_q  <= '0;
		end else begin
			if (ctl.observe) begin
				if (cmd_q == CMD_OBSERVE && line_q) begin
					// A line error latches even while stopped.
					if (!fault_q) begin
						err_q <= err_q + 1'b1;
					end
					fault_q <= 1'b1;
				end else if (obs_en) begin
					if (dma_err_q || rem_bad) begin
						err_q   <= err_q + 1'b1;
						fault_q <= 1'b1;
					end else if (half_q && full_q) begin
						err_q   <= err_q + 1'b1;
						ovf_q   <= ovf_q + 1'b1;
						fault_q <= 1'b1;
					end else begin
						wc_q   <= wc_q + CNT_W'(delta);
						last_q <= pos16[RW-1:0];
					end
				end
			end
			if (ctl.check && obs_en && ({1'b0, fill} >= RING_EXT)) begin
				err_q   <= err_q + 1'b1;
				ovf_q   <= ovf_q + 1'b1;
				fault_q <= 1'b1;
			end
			if (ctl.act) begin
				case (cmd_q)
					CMD_GRANT: pend_q <= grant_n[PW-1:0];
					CMD_COMMIT: begin
						rc_q   <= rc_q + commit_n;
						pend_q <= '0;
					end
					CMD_FLUSH: begin
						rc_q   <= wc_q;
						pend_q <= '0;
					end
					CMD_STOP: begin
						recv_q <= 1'b0;
						wc_q   <= '0;
						rc_q   <= '0;
						last_q <= '0;
						pend_q <= '0;
					end
					CMD_RESTART: begin
						recv_q  <= 1'b1;
						fault_q <= 1'b0;
						wc_q    <= '0;
						rc_q    <= '0;
						last_q  <= '0;
						pend_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign available      = avail_q;
	assign grant_start    = gstart_q;
	assign grant_count    = gcount_q;
	assign faulted        = fault_q;
	assign error_total    = err_q;
	assign overflow_total = ovf_q;

	a_fault_counts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fault_q) |-> err_q == $past(err_q) + 1'b1)
		else $error("fault latched without counting an error");

	a_ovf_with_err: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ovf_q) |-> !$stable(err_q))
		else $error("overflow counted without an error");

	a_pend_limit: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pend_q) <= LIMIT)
		else $error("pending grant above read limit");

	a_fault_avail: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish && fault_q |=> avail_q == '0)
		else $error("nonzero availability while faulted");

endmodule

// ===== sv/dma_rx_ring_tracker_unit.sv =====
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+------------------------------
// item in  | command dma_error half_mark full_mark remaining    | taken when start && !busy
//          | line_error read_max                                |
// result   | available grant_start grant_count faulted          | shown one cycle with done
//          | error_total overflow_total                         |
//
// Each item walks through the observation update, the overflow check, the command action
// and the fill calculation, then a result cycle marked by done.
// The controller walks the datapath one step a cycle.
// busy is low in the result cycle, so the next item may be taken at the edge ending it.
// Reset (arst_n low) clears all counts, the fault latch and the receiving flag.
// The receiver cannot stall: a result is valid only in the cycle done is high.
module dma_rx_ring_tracker_unit #(
	parameter int RING_SIZE  = drrt_pkg::DEF_RING_SIZE,
	parameter int READ_LIMIT = drrt_pkg::DEF_READ_LIMIT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [drrt_pkg::CMD_W-1:0]   command,
	input  logic                         dma_error,
	input  logic                         half_mark,
	input  logic                         full_mark,
	input  logic [drrt_pkg::CNT_W-1:0]   remaining,
	input  logic                         line_error,
	input  logic [drrt_pkg::CNT_W-1:0]   read_max,
	output logic                         done,
	output logic [drrt_pkg::AVAIL_W-1:0] available,
	output logic [drrt_pkg::START_W-1:0] grant_start,
	output logic [drrt_pkg::GCNT_W-1:0]  grant_count,
	output logic                         faulted,
	output logic [drrt_pkg::TOT_W-1:0]   error_total,
	output logic [drrt_pkg::TOT_W-1:0]   overflow_total
);
	import drrt_pkg::*;

	// The controller only sequences; every count and latch lives in the datapath.
	drrt_ctl_t ctl;

	drrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// The datapath captures the item on the accept edge, advances the write count from
	// the DMA remaining count, latches faults (counting only the first one), and then
	// applies the grant, commit, flush, stop or restart action.
	drrt_dp #(
		.RING_SIZE  (RING_SIZE),
		.READ_LIMIT (READ_LIMIT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.command        (command),
		.dma_error      (dma_error),
		.half_mark      (half_mark),
		.full_mark      (full_mark),
		.remaining      (remaining),
		.line_error     (line_error),
		.read_max       (read_max),
		.available      (available),
		.grant_start    (grant_start),
		.grant_count    (grant_count),
		.faulted        (faulted),
		.error_total    (error_total),
		.overflow_total (overflow_total)
	);

endmodule
